@@ src/drs_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Delta-rule state scan package
// Shared constants, queue entry layout, buffer word layout and fixed-point
// helpers.
// ----------------------------------------------------------------------------
package drs_pkg;

  localparam int HEAD_DIM  = 64;
  localparam int SLOTS     = 8;
  localparam int FRAC_BITS = 24;

  localparam int IDX_W  = 6;
  localparam int SLOT_W = 3;
  localparam int WORD_W = 32;
  localparam int ADDR_W = SLOT_W + 2 * IDX_W;
  localparam int PROD_W = 2 * WORD_W - FRAC_BITS;
  localparam int ACC_W  = PROD_W + IDX_W + 2;
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = 2;

  localparam logic [1:0] CMD_TOKEN = 2'd0;
  localparam logic [1:0] CMD_WRITE = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(HEAD_DIM - 1);

  typedef enum logic [1:0] {
    OP_LOAD,
    OP_UPDATE,
    OP_WRITE,
    OP_READ
  } op_e;

  typedef struct packed {
    logic signed [WORD_W-1:0] r;
    logic signed [WORD_W-1:0] v;
    logic signed [WORD_W-1:0] w;
    logic signed [WORD_W-1:0] kk;
    logic signed [WORD_W-1:0] kt;
    logic signed [WORD_W-1:0] a;
  } buf_word_t;

  typedef struct packed {
    op_e                      op;
    logic [SLOT_W-1:0]        slot;
    logic [IDX_W-1:0]         idx;
    logic [IDX_W-1:0]         col;
    buf_word_t                vec;
    logic signed [WORD_W-1:0] state_word;
  } entry_t;

  typedef struct packed {
    logic clearing;
  } back_status_t;

  function automatic logic [WORD_W-1:0] sat32(input logic signed [ACC_W-1:0] x);
    logic [ACC_W-WORD_W:0] top;
    top = x[ACC_W-1:WORD_W-1];
    if ((&top) || !(|top)) begin
      return x[WORD_W-1:0];
    end else if (x[ACC_W-1]) begin
      return {1'b1, {(WORD_W-1){1'b0}}};
    end else begin
      return {1'b0, {(WORD_W-1){1'b1}}};
    end
  endfunction

  function automatic logic signed [ACC_W-1:0] widen(input logic signed [PROD_W-1:0] p);
    return {{(ACC_W-PROD_W){p[PROD_W-1]}}, p};
  endfunction

endpackage

@@ src/delta_rule_state_scan.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Delta-rule state scan
// Per-slot 64x64 Q8.24 state with delta-rule row updates, word writes and
// word reads.
// ----------------------------------------------------------------------------
// Loads and writes are handled in the sequencer's idle state; a read first
// registers the state word, then passes it to the output register. The final
// token element forms the key-rate products, then for each row runs a dot
// product pass and an update pass over the state words, for 64 results, with
// one shared multiplier and a single-port state memory. A clearing pass
// after reset zeroes all 32,768 state words; no item is accepted during it.
module delta_rule_state_scan (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [1:0]                    command_i,
  input  logic [drs_pkg::SLOT_W-1:0]    slot_i,
  input  logic [drs_pkg::IDX_W-1:0]     elem_index_i,
  input  logic [drs_pkg::IDX_W-1:0]     column_i,
  input  logic signed [31:0]            receptance_i,
  input  logic signed [31:0]            value_elem_i,
  input  logic signed [31:0]            decay_i,
  input  logic signed [31:0]            removal_key_i,
  input  logic signed [31:0]            write_key_i,
  input  logic signed [31:0]            in_context_rate_i,
  input  logic signed [31:0]            state_word_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic signed [31:0]            result_value_o,
  output logic [drs_pkg::IDX_W-1:0]     result_row_o,
  output logic                          last_o
);
  import drs_pkg::*;

  back_status_t status;
  entry_t       push_entry, head;
  logic         push, full, pop, empty;

  drs_front u_front (
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .command_i         (command_i),
    .slot_i            (slot_i),
    .elem_index_i      (elem_index_i),
    .column_i          (column_i),
    .receptance_i      (receptance_i),
    .value_elem_i      (value_elem_i),
    .decay_i           (decay_i),
    .removal_key_i     (removal_key_i),
    .write_key_i       (write_key_i),
    .in_context_rate_i (in_context_rate_i),
    .state_word_i      (state_word_i),
    .status_i          (status),
    .fifo_full_i       (full),
    .push_o            (push),
    .entry_o           (push_entry)
  );

  drs_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (push_entry),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .head_o  (head)
  );

  drs_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .fifo_empty_i   (empty),
    .head_i         (head),
    .pop_o          (pop),
    .status_o       (status),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .result_value_o (result_value_o),
    .result_row_o   (result_row_o),
    .last_o         (last_o)
  );

endmodule

@@ src/drs_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Delta-rule state scan front end
// Accepts input items, classifies them and pushes work into the queue.
// ----------------------------------------------------------------------------
module drs_front (
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [1:0]                    command_i,
  input  logic [drs_pkg::SLOT_W-1:0]    slot_i,
  input  logic [drs_pkg::IDX_W-1:0]     elem_index_i,
  input  logic [drs_pkg::IDX_W-1:0]     column_i,
  input  logic signed [31:0]            receptance_i,
  input  logic signed [31:0]            value_elem_i,
  input  logic signed [31:0]            decay_i,
  input  logic signed [31:0]            removal_key_i,
  input  logic signed [31:0]            write_key_i,
  input  logic signed [31:0]            in_context_rate_i,
  input  logic signed [31:0]            state_word_i,
  input  drs_pkg::back_status_t         status_i,
  input  logic                          fifo_full_i,
  output logic                          push_o,
  output drs_pkg::entry_t               entry_o
);
  import drs_pkg::*;

  logic accept;

  assign in_ready_o = !fifo_full_i && !status_i.clearing;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    entry_o.slot       = slot_i;
    entry_o.idx        = elem_index_i;
    entry_o.col        = column_i;
    entry_o.vec.r      = receptance_i;
    entry_o.vec.v      = value_elem_i;
    entry_o.vec.w      = decay_i;
    entry_o.vec.kk     = removal_key_i;
    entry_o.vec.kt     = write_key_i;
    entry_o.vec.a      = in_context_rate_i;
    entry_o.state_word = state_word_i;
    entry_o.op         = OP_LOAD;
    push_o             = accept;
    case (command_i)
      CMD_TOKEN: entry_o.op = (elem_index_i == LAST_IDX) ? OP_UPDATE : OP_LOAD;
      CMD_WRITE: entry_o.op = OP_WRITE;
      CMD_READ:  entry_o.op = OP_READ;
      default:   push_o     = 1'b0;
    endcase
  end

endmodule

@@ src/drs_fifo.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Delta-rule state scan work queue
// Short queue that decouples the front end from the sequencer.
// ----------------------------------------------------------------------------
module drs_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  drs_pkg::entry_t entry_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            empty_o,
  output drs_pkg::entry_t head_o
);
  import drs_pkg::*;

  entry_t                mem_q [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_q, rd_q;
  logic [FIFO_PTR_W:0]   cnt_q;

  assign full_o  = (cnt_q == (FIFO_PTR_W + 1)'(FIFO_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign head_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i && !full_o) begin
      mem_q[wr_q] <= entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i && !full_o) begin
        wr_q <= wr_q + 1'b1;
      end
      if (pop_i && !empty_o) begin
        rd_q <= rd_q + 1'b1;
      end
      case ({push_i && !full_o, pop_i && !empty_o})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

@@ src/drs_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Delta-rule state scan sequencer
// Holds the state matrices and buffers and runs the row updates with one
// shared multiplier.
// ----------------------------------------------------------------------------
module drs_back (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       fifo_empty_i,
  input  drs_pkg::entry_t            head_i,
  output logic                       pop_o,
  output drs_pkg::back_status_t      status_o,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic signed [31:0]         result_value_o,
  output logic [drs_pkg::IDX_W-1:0]  result_row_o,
  output logic                       last_o
);
  import drs_pkg::*;

  localparam logic [4:0] S_CLEAR     = 5'd0;
  localparam logic [4:0] S_IDLE      = 5'd1;
  localparam logic [4:0] S_READ_OUT  = 5'd2;
  localparam logic [4:0] S_KKA_RD    = 5'd3;
  localparam logic [4:0] S_KKA_MUL   = 5'd4;
  localparam logic [4:0] S_KKA_WR    = 5'd5;
  localparam logic [4:0] S_ROW_START = 5'd6;
  localparam logic [4:0] S_ROW_VI    = 5'd7;
  localparam logic [4:0] S_DOT_RD    = 5'd8;
  localparam logic [4:0] S_DOT_MUL   = 5'd9;
  localparam logic [4:0] S_DOT_ACC   = 5'd10;
  localparam logic [4:0] S_UPD_RD    = 5'd11;
  localparam logic [4:0] S_UPD_M1    = 5'd12;
  localparam logic [4:0] S_UPD_M2    = 5'd13;
  localparam logic [4:0] S_UPD_M3    = 5'd14;
  localparam logic [4:0] S_UPD_WR    = 5'd15;
  localparam logic [4:0] S_OUT_MUL   = 5'd16;
  localparam logic [4:0] S_OUT_ACC   = 5'd17;
  localparam logic [4:0] S_EMIT      = 5'd18;

  logic [4:0]               state_q, state_d;
  logic [SLOT_W-1:0]        slot_q, slot_d;
  logic [IDX_W-1:0]         row_q, row_d;
  logic [IDX_W-1:0]         col_q, col_d;
  logic [ADDR_W-1:0]        clr_q, clr_d;
  logic signed [WORD_W-1:0] vi_q, vi_d;
  logic signed [WORD_W-1:0] s_q, s_d;
  logic signed [WORD_W-1:0] nv_q, nv_d;
  logic signed [WORD_W-1:0] res_q, res_d;
  logic signed [ACC_W-1:0]  acc_q, acc_d;
  logic signed [ACC_W-1:0]  t_q, t_d;
  logic signed [PROD_W-1:0] prod_q;

  logic                     out_valid_q;
  logic signed [WORD_W-1:0] out_value_q;
  logic [IDX_W-1:0]         out_row_q;
  logic                     out_last_q;
  logic                     out_load;
  logic signed [WORD_W-1:0] out_value_d;
  logic [IDX_W-1:0]         out_row_d;
  logic                     out_last_d;
  logic                     out_free;

  logic signed [WORD_W-1:0] st_mem [SLOTS * HEAD_DIM * HEAD_DIM];
  logic signed [WORD_W-1:0] st_rd_q;
  logic                     st_we, st_re;
  logic [ADDR_W-1:0]        st_addr;
  logic signed [WORD_W-1:0] st_wdata;

  buf_word_t                buf_mem [HEAD_DIM];
  buf_word_t                buf_rd_q;
  logic                     buf_we, buf_re;
  logic [IDX_W-1:0]         buf_waddr, buf_raddr;

  logic signed [WORD_W-1:0] kka_mem [HEAD_DIM];
  logic signed [WORD_W-1:0] kka_rd_q;
  logic                     kka_we, kka_re;

  logic signed [WORD_W-1:0]   mul_a, mul_b;
  logic signed [2*WORD_W-1:0] mul_p;
  logic signed [ACC_W-1:0]    acc_sum;

  assign out_free = !out_valid_q || out_ready_i;
  assign mul_p    = mul_a * mul_b;
  assign acc_sum  = acc_q + widen(prod_q);

  always_ff @(posedge clk_i) begin
    if (st_we) begin
      st_mem[st_addr] <= st_wdata;
    end
    if (st_re) begin
      st_rd_q <= st_mem[st_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (buf_we) begin
      buf_mem[buf_waddr] <= head_i.vec;
    end
    if (buf_re) begin
      buf_rd_q <= buf_mem[buf_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (kka_we) begin
      kka_mem[col_q] <= sat32(widen(prod_q));
    end
    if (kka_re) begin
      kka_rd_q <= kka_mem[col_q];
    end
  end

  always_comb begin
    mul_a = st_rd_q;
    mul_b = buf_rd_q.kk;
    case (state_q)
      S_KKA_MUL: begin
        mul_a = buf_rd_q.kk;
        mul_b = buf_rd_q.a;
      end
      S_UPD_M1: mul_b = buf_rd_q.w;
      S_UPD_M2: begin
        mul_a = vi_q;
        mul_b = buf_rd_q.kt;
      end
      S_UPD_M3: begin
        mul_a = s_q;
        mul_b = kka_rd_q;
      end
      S_OUT_MUL: begin
        mul_a = nv_q;
        mul_b = buf_rd_q.r;
      end
      default: ;
    endcase
  end

  always_comb begin
    state_d     = state_q;
    slot_d      = slot_q;
    row_d       = row_q;
    col_d       = col_q;
    clr_d       = clr_q;
    vi_d        = vi_q;
    s_d         = s_q;
    nv_d        = nv_q;
    res_d       = res_q;
    acc_d       = acc_q;
    t_d         = t_q;
    pop_o       = 1'b0;
    st_we       = 1'b0;
    st_re       = 1'b0;
    st_addr     = {slot_q, row_q, col_q};
    st_wdata    = '0;
    buf_we      = 1'b0;
    buf_re      = 1'b0;
    buf_waddr   = head_i.idx;
    buf_raddr   = col_q;
    kka_we      = 1'b0;
    kka_re      = 1'b0;
    out_load    = 1'b0;
    out_value_d = res_q;
    out_row_d   = row_q;
    out_last_d  = 1'b1;
    case (state_q)
      S_CLEAR: begin
        st_we   = 1'b1;
        st_addr = clr_q;
        clr_d   = clr_q + 1'b1;
        if (&clr_q) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (!fifo_empty_i) begin
          pop_o = 1'b1;
          case (head_i.op)
            OP_LOAD: buf_we = 1'b1;
            OP_UPDATE: begin
              buf_we  = 1'b1;
              slot_d  = head_i.slot;
              col_d   = '0;
              state_d = S_KKA_RD;
            end
            OP_WRITE: begin
              st_we    = 1'b1;
              st_addr  = {head_i.slot, head_i.idx, head_i.col};
              st_wdata = head_i.state_word;
            end
            OP_READ: begin
              st_re   = 1'b1;
              st_addr = {head_i.slot, head_i.idx, head_i.col};
              row_d   = head_i.idx;
              state_d = S_READ_OUT;
            end
            default: ;
          endcase
        end
      end
      S_READ_OUT: begin
        if (out_free) begin
          out_load    = 1'b1;
          out_value_d = st_rd_q;
          state_d     = S_IDLE;
        end
      end
      S_KKA_RD: begin
        buf_re  = 1'b1;
        state_d = S_KKA_MUL;
      end
      S_KKA_MUL: state_d = S_KKA_WR;
      S_KKA_WR: begin
        kka_we = 1'b1;
        col_d  = col_q + 1'b1;
        if (col_q == LAST_IDX) begin
          row_d   = '0;
          state_d = S_ROW_START;
        end else begin
          state_d = S_KKA_RD;
        end
      end
      S_ROW_START: begin
        buf_re    = 1'b1;
        buf_raddr = row_q;
        state_d   = S_ROW_VI;
      end
      S_ROW_VI: begin
        vi_d    = buf_rd_q.v;
        acc_d   = '0;
        col_d   = '0;
        state_d = S_DOT_RD;
      end
      S_DOT_RD: begin
        st_re   = 1'b1;
        buf_re  = 1'b1;
        state_d = S_DOT_MUL;
      end
      S_DOT_MUL: state_d = S_DOT_ACC;
      S_DOT_ACC: begin
        col_d = col_q + 1'b1;
        if (col_q == LAST_IDX) begin
          s_d     = sat32(acc_sum);
          acc_d   = '0;
          state_d = S_UPD_RD;
        end else begin
          acc_d   = acc_sum;
          state_d = S_DOT_RD;
        end
      end
      S_UPD_RD: begin
        st_re   = 1'b1;
        buf_re  = 1'b1;
        kka_re  = 1'b1;
        state_d = S_UPD_M1;
      end
      S_UPD_M1: state_d = S_UPD_M2;
      S_UPD_M2: begin
        t_d     = widen(prod_q);
        state_d = S_UPD_M3;
      end
      S_UPD_M3: begin
        t_d     = t_q + widen(prod_q);
        state_d = S_UPD_WR;
      end
      S_UPD_WR: begin
        st_we    = 1'b1;
        st_wdata = sat32(t_q - widen(prod_q));
        nv_d     = st_wdata;
        state_d  = S_OUT_MUL;
      end
      S_OUT_MUL: state_d = S_OUT_ACC;
      S_OUT_ACC: begin
        col_d = col_q + 1'b1;
        if (col_q == LAST_IDX) begin
          res_d   = sat32(acc_sum);
          state_d = S_EMIT;
        end else begin
          acc_d   = acc_sum;
          state_d = S_UPD_RD;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          out_load   = 1'b1;
          out_last_d = (row_q == LAST_IDX);
          if (row_q == LAST_IDX) begin
            state_d = S_IDLE;
          end else begin
            row_d   = row_q + 1'b1;
            state_d = S_ROW_START;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    prod_q <= mul_p[2*WORD_W-1:FRAC_BITS];
    slot_q <= slot_d;
    row_q  <= row_d;
    col_q  <= col_d;
    vi_q   <= vi_d;
    s_q    <= s_d;
    nv_q   <= nv_d;
    res_q  <= res_d;
    acc_q  <= acc_d;
    t_q    <= t_d;
    if (out_load) begin
      out_value_q <= out_value_d;
      out_row_q   <= out_row_d;
      out_last_q  <= out_last_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign status_o.clearing = (state_q == S_CLEAR);
  assign out_valid_o       = out_valid_q;
  assign result_value_o    = out_value_q;
  assign result_row_o      = out_row_q;
  assign last_o            = out_last_q;

  a_pop_nonempty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |-> !fifo_empty_i)
    else $error("Queue popped while empty.");

  a_wr_then_out : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_UPD_WR |=> state_q == S_OUT_MUL)
    else $error("Updated word not folded into the output sum.");

  a_emit_next_row : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EMIT && out_load && row_q != LAST_IDX) |=>
      (state_q == S_ROW_START && out_valid_q))
    else $error("Row sequence broken after a result.");

  a_load_when_free : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> (!out_valid_q || out_ready_i))
    else $error("Result overwrote a pending item.");

endmodule
